// ===== rtl/core/vruntime_ordered_run_queue_assert.svh =====
// Assertion macros shared by the run queue RTL
`ifndef VRUNTIME_ORDERED_RUN_QUEUE_ASSERT_SVH
`define VRUNTIME_ORDERED_RUN_QUEUE_ASSERT_SVH

// same-cycle implication
`define VORQ_ASSERT_NOW(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define VORQ_ASSERT_NXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/vorq_pkg.sv =====
// Package: types and constants of the run queue
`timescale 1ns / 1ps
package vorq_pkg;

  localparam int QUEUE_DEPTH_DEF  = 16;
  localparam int TASK_ID_BITS_DEF = 8;
  localparam int RUNTIME_W        = 64;

  typedef enum logic [1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_REMOVE = 2'd1,
    FUNC_PEEK   = 2'd2,
    FUNC_RSVD   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_IGNORED = 2'd1,
    ST_FULL    = 2'd2,
    ST_DUP     = 2'd3
  } status_t;

  typedef struct packed {
    func_t                  func;
    logic [7:0]             task_id;
    logic [RUNTIME_W-1:0]   task_vruntime;
    logic                   task_blocked;
  } request_t;

  typedef struct packed {
    status_t    status;
    logic       head_valid;
    logic [7:0] head_task;
    logic [4:0] running_count;
  } result_t;

  typedef struct packed {
    logic eval;
    logic ins;
    logic rem;
  } cell_op_t;

endpackage

// ===== rtl/core/vruntime_ordered_run_queue.sv =====
// Top level: run queue of task identifiers sorted by virtual runtime
// Usage:
//   Drive request and raise start; the item is taken at a rising edge with
//   start high and busy low. insert places a runnable task behind every entry
//   whose runtime is not greater; remove takes a task out by identifier;
//   peek changes nothing. Each item yields one result on result, marked by
//   done for exactly one cycle, with status, head task and entry count.
//   An item passes through compare (every slot compares its entry
//   against the key at once), then update (slots shift in parallel);
//   done rises as update ends. busy is high only in the compare state,
//   so a new item can be taken in the update state of the one before.
//   The slots form a chain; each moves data to or from its neighbours.
//   Reset empties the queue (count to zero); entry storage is not cleared.
//   The receiver cannot stall: each result is valid for its one done cycle.
`timescale 1ns / 1ps
`include "vruntime_ordered_run_queue_assert.svh"
module vruntime_ordered_run_queue #(
  parameter int QUEUE_DEPTH  = vorq_pkg::QUEUE_DEPTH_DEF,
  parameter int TASK_ID_BITS = vorq_pkg::TASK_ID_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  vorq_pkg::request_t request,
  output logic               done,
  output vorq_pkg::result_t  result
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [QUEUE_DEPTH-1:0] ONES = {QUEUE_DEPTH{1'b1}};

  typedef enum logic [1:0] {S_IDLE, S_EVAL, S_APPLY} state_t;

  state_t                         state;
  vorq_pkg::request_t             cmd;
  logic [CNT_W-1:0]               count;
  logic [CNT_W-1:0]               count_next;
  vorq_pkg::cell_op_t             op;
  vorq_pkg::status_t              status_next;
  logic                           do_ins;
  logic                           do_rem;
  logic                           any_match;
  logic                           accept;
  logic [TASK_ID_BITS-1:0]        key_id;

  logic [vorq_pkg::RUNTIME_W-1:0] cell_rt      [QUEUE_DEPTH];
  logic [TASK_ID_BITS-1:0]        cell_id      [QUEUE_DEPTH];
  logic [TASK_ID_BITS-1:0]        cell_id_next [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0]         behind;
  logic [QUEUE_DEPTH-1:0]         match;
  logic [QUEUE_DEPTH-1:0]         past;

  assign busy      = (state == S_EVAL);
  assign accept    = start && !busy;
  assign key_id    = TASK_ID_BITS'(cmd.task_id);
  assign any_match = |match;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic [vorq_pkg::RUNTIME_W-1:0] p_rt;
    logic [TASK_ID_BITS-1:0]        p_id;
    logic                           p_behind;
    logic [vorq_pkg::RUNTIME_W-1:0] n_rt;
    logic [TASK_ID_BITS-1:0]        n_id;

    if (i == 0) begin : g_first
      assign p_rt     = '0;
      assign p_id     = '0;
      assign p_behind = 1'b0;
    end else begin : g_mid
      assign p_rt     = cell_rt[i-1];
      assign p_id     = cell_id[i-1];
      assign p_behind = behind[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign n_rt = '0;
      assign n_id = '0;
    end else begin : g_inner
      assign n_rt = cell_rt[i+1];
      assign n_id = cell_id[i+1];
    end

    assign past[i] = |(match & (ONES >> (QUEUE_DEPTH - 1 - i)));

    vorq_cell #(
      .IDX          (i),
      .CNT_W        (CNT_W),
      .TASK_ID_BITS (TASK_ID_BITS)
    ) u_cell (
      .clk         (clk),
      .op          (op),
      .count       (count),
      .key_rt      (cmd.task_vruntime),
      .key_id      (key_id),
      .prev_rt     (p_rt),
      .prev_id     (p_id),
      .prev_behind (p_behind),
      .next_rt     (n_rt),
      .next_id     (n_id),
      .past        (past[i]),
      .rt          (cell_rt[i]),
      .id          (cell_id[i]),
      .id_next     (cell_id_next[i]),
      .behind      (behind[i]),
      .match       (match[i])
    );
  end

  always_comb begin
    status_next = vorq_pkg::ST_DONE;
    do_ins      = 1'b0;
    do_rem      = 1'b0;
    unique case (cmd.func)
      vorq_pkg::FUNC_INSERT: begin
        priority if (cmd.task_blocked) begin
          status_next = vorq_pkg::ST_IGNORED;
        end else if (any_match) begin
          status_next = vorq_pkg::ST_DUP;
        end else if (count == CNT_W'(QUEUE_DEPTH)) begin
          status_next = vorq_pkg::ST_FULL;
        end else begin
          do_ins = 1'b1;
        end
      end
      vorq_pkg::FUNC_REMOVE: begin
        if (any_match) begin
          do_rem = 1'b1;
        end else begin
          status_next = vorq_pkg::ST_IGNORED;
        end
      end
      vorq_pkg::FUNC_PEEK: status_next = vorq_pkg::ST_DONE;
      vorq_pkg::FUNC_RSVD: status_next = vorq_pkg::ST_IGNORED;
      default:             status_next = vorq_pkg::ST_IGNORED;
    endcase
  end

  always_comb begin
    op.eval = (state == S_EVAL);
    op.ins  = (state == S_APPLY) && do_ins;
    op.rem  = (state == S_APPLY) && do_rem;
    count_next = count;
    if (op.ins) begin
      count_next = count + CNT_W'(1);
    end else if (op.rem) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (accept) begin
        cmd <= request;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) state <= S_EVAL;
        end
        S_EVAL: begin
          state <= S_APPLY;
        end
        S_APPLY: begin
          count                <= count_next;
          done                 <= 1'b1;
          result.status        <= status_next;
          result.head_valid    <= (count_next != '0);
          result.head_task     <= (count_next != '0) ? 8'(cell_id_next[0]) : 8'd0;
          result.running_count <= 5'(count_next);
          state                <= accept ? S_EVAL : S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `VORQ_ASSERT_NXT(a_apply_gives_done, clk, rst, state == S_APPLY, done, "no result after update")
  `VORQ_ASSERT_NOW(a_done_from_apply, clk, rst, done, $past(state == S_APPLY), "stray result strobe")
  `VORQ_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, count <= CNT_W'(QUEUE_DEPTH), "count past depth")
  `VORQ_ASSERT_NXT(a_ins_count, clk, rst, op.ins, count == $past(count) + CNT_W'(1), "ins lost")
  `VORQ_ASSERT_NOW(a_head_valid, clk, rst, done, result.head_valid == |count, "head flag off")

endmodule

// ===== rtl/core/vorq_cell.sv =====
// One queue slot: holds an entry, compares against the key, shifts to/from neighbours
`timescale 1ns / 1ps
module vorq_cell #(
  parameter int IDX          = 0,
  parameter int CNT_W        = 5,
  parameter int TASK_ID_BITS = vorq_pkg::TASK_ID_BITS_DEF
) (
  input  logic                           clk,
  input  vorq_pkg::cell_op_t             op,
  input  logic [CNT_W-1:0]               count,
  input  logic [vorq_pkg::RUNTIME_W-1:0] key_rt,
  input  logic [TASK_ID_BITS-1:0]        key_id,
  input  logic [vorq_pkg::RUNTIME_W-1:0] prev_rt,
  input  logic [TASK_ID_BITS-1:0]        prev_id,
  input  logic                           prev_behind,
  input  logic [vorq_pkg::RUNTIME_W-1:0] next_rt,
  input  logic [TASK_ID_BITS-1:0]        next_id,
  input  logic                           past,
  output logic [vorq_pkg::RUNTIME_W-1:0] rt,
  output logic [TASK_ID_BITS-1:0]        id,
  output logic [TASK_ID_BITS-1:0]        id_next,
  output logic                           behind,
  output logic                           match
);

  logic                           occupied;
  logic [vorq_pkg::RUNTIME_W-1:0] rt_next;

  assign occupied = count > CNT_W'(IDX);

  always_comb begin
    rt_next = rt;
    id_next = id;
    if (op.ins && behind) begin
      if (prev_behind) begin
        rt_next = prev_rt;
        id_next = prev_id;
      end else begin
        rt_next = key_rt;
        id_next = key_id;
      end
    end else if (op.rem && past) begin
      rt_next = next_rt;
      id_next = next_id;
    end
  end

  always_ff @(posedge clk) begin
    if (op.eval) begin
      behind <= !occupied || (rt > key_rt);
      match  <= occupied && (id == key_id);
    end
    rt <= rt_next;
    id <= id_next;
  end

endmodule

// ===== tb/tb_vruntime_ordered_run_queue.sv =====
// Testbench for the run queue: directed and random items checked against a predictor
`timescale 1ns / 1ps
module tb_vruntime_ordered_run_queue;

  localparam int DEPTH      = vorq_pkg::QUEUE_DEPTH_DEF;
  localparam int IDLE_LIMIT = 500;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  vorq_pkg::request_t request = '0;
  logic               done;
  vorq_pkg::result_t  result;

  logic [vorq_pkg::RUNTIME_W-1:0] runq_rt [DEPTH];
  logic [7:0]                     runq_id [DEPTH];
  int                             runq_len = 0;

  vorq_pkg::result_t pending [$];
  int                mismatches = 0;
  int                idle_cycles = 0;
  bit                back_to_back = 1'b0;

  vruntime_ordered_run_queue dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result)
  );

  always #5 clk = ~clk;

  function automatic vorq_pkg::request_t make_item(vorq_pkg::func_t f, logic [7:0] id,
                                                   logic [vorq_pkg::RUNTIME_W-1:0] rt,
                                                   logic blk);
    vorq_pkg::request_t item;
    item.func          = f;
    item.task_id       = id;
    item.task_vruntime = rt;
    item.task_blocked  = blk;
    return item;
  endfunction

  function automatic vorq_pkg::result_t predict_run_queue(vorq_pkg::request_t item);
    vorq_pkg::result_t res;
    int                slot;
    int                pos;
    int                i;
    slot = -1;
    for (i = 0; i < runq_len; i++)
      if (slot < 0 && runq_id[i] == item.task_id) slot = i;
    case (item.func)
      vorq_pkg::FUNC_INSERT: begin
        if (item.task_blocked) res.status = vorq_pkg::ST_IGNORED;
        else if (slot >= 0) res.status = vorq_pkg::ST_DUP;
        else if (runq_len >= DEPTH) res.status = vorq_pkg::ST_FULL;
        else begin
          pos = runq_len;
          for (i = 0; i < runq_len; i++)
            if (pos == runq_len && runq_rt[i] > item.task_vruntime) pos = i;
          for (i = runq_len; i > pos; i--) begin
            runq_rt[i] = runq_rt[i-1];
            runq_id[i] = runq_id[i-1];
          end
          runq_rt[pos] = item.task_vruntime;
          runq_id[pos] = item.task_id;
          runq_len++;
          res.status = vorq_pkg::ST_DONE;
        end
      end
      vorq_pkg::FUNC_REMOVE: begin
        if (slot < 0) res.status = vorq_pkg::ST_IGNORED;
        else begin
          for (i = slot; i + 1 < runq_len; i++) begin
            runq_rt[i] = runq_rt[i+1];
            runq_id[i] = runq_id[i+1];
          end
          runq_len--;
          res.status = vorq_pkg::ST_DONE;
        end
      end
      vorq_pkg::FUNC_PEEK: res.status = vorq_pkg::ST_DONE;
      default:             res.status = vorq_pkg::ST_IGNORED;
    endcase
    res.head_valid    = (runq_len > 0);
    res.head_task     = (runq_len > 0) ? runq_id[0] : 8'd0;
    res.running_count = 5'(runq_len);
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic issue_item(vorq_pkg::request_t item);
    int gap;
    request <= item;
    start   <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending.push_back(predict_run_queue(item));
    gap = back_to_back ? 0 : pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic test_empty_queue();
    issue_item(make_item(vorq_pkg::FUNC_PEEK, 8'h00, '0, 1'b0));
    issue_item(make_item(vorq_pkg::FUNC_REMOVE, 8'h5A, '0, 1'b0));
    issue_item(make_item(vorq_pkg::FUNC_RSVD, 8'hFF, '1, 1'b1));
    issue_item(make_item(vorq_pkg::FUNC_INSERT, 8'hFF, '1, 1'b1));
  endtask

  task automatic test_ordering();
    issue_item(make_item(vorq_pkg::FUNC_INSERT, 8'h00, '1, 1'b0));
    issue_item(make_item(vorq_pkg::FUNC_INSERT, 8'hFF, '0, 1'b0));
    issue_item(make_item(vorq_pkg::FUNC_INSERT, 8'h11, 64'd100, 1'b0));
    issue_item(make_item(vorq_pkg::FUNC_INSERT, 8'h22, 64'd100, 1'b0));
    issue_item(make_item(vorq_pkg::FUNC_INSERT, 8'h11, 64'd5, 1'b0));
    issue_item(make_item(vorq_pkg::FUNC_REMOVE, 8'hFF, '0, 1'b0));
  endtask

  task automatic test_full_queue();
    int i;
    for (i = 0; i < DEPTH - 3; i++)
      issue_item(make_item(vorq_pkg::FUNC_INSERT, 8'h40 + 8'(i), 64'((i % 4) * 50), 1'b0));
    issue_item(make_item(vorq_pkg::FUNC_INSERT, 8'h80, 64'd1, 1'b0));
    issue_item(make_item(vorq_pkg::FUNC_INSERT, 8'h11, 64'd1, 1'b0));
  endtask

  task automatic test_random_mix();
    int                             burst;
    int                             n;
    int                             bias;
    int                             r;
    logic [7:0]                     id_mask;
    logic [7:0]                     id;
    logic [vorq_pkg::RUNTIME_W-1:0] rt;
    vorq_pkg::func_t                f;
    for (burst = 0; burst < 30; burst++) begin
      bias         = $urandom_range(20, 80);
      id_mask      = 8'($urandom);
      back_to_back = ($urandom_range(0, 3) == 0);
      for (n = 0; n < 50; n++) begin
        r = $urandom_range(0, 99);
        if (r < bias) f = vorq_pkg::FUNC_INSERT;
        else if (r < 95) f = vorq_pkg::FUNC_REMOVE;
        else if (r < 98) f = vorq_pkg::FUNC_PEEK;
        else f = vorq_pkg::FUNC_RSVD;
        if ($urandom_range(0, 9) == 0) id = 8'($urandom);
        else id = 8'($urandom_range(0, 23)) ^ id_mask;
        if (f == vorq_pkg::FUNC_REMOVE && runq_len > 0 && $urandom_range(0, 9) < 7)
          id = runq_id[$urandom_range(0, runq_len - 1)];
        r = $urandom_range(0, 99);
        if (r < 5) rt = '0;
        else if (r < 10) rt = '1;
        else if (r < 50) rt = vorq_pkg::RUNTIME_W'($urandom_range(0, 7));
        else rt = {$urandom, $urandom};
        issue_item(make_item(f, id, rt, ($urandom_range(0, 9) == 0)));
      end
    end
    back_to_back = 1'b0;
  endtask

  always @(posedge clk) begin
    vorq_pkg::result_t want;
    if (!rst && done) begin
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: %p", result);
      end else begin
        want = pending.pop_front();
        if (result.status !== want.status || result.head_valid !== want.head_valid ||
            result.head_task !== want.head_task ||
            result.running_count !== want.running_count) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: expected status %0d valid %0b head %02h count %0d,",
                      " got status %0d valid %0b head %02h count %0d"},
                     want.status, want.head_valid, want.head_task, want.running_count,
                     result.status, result.head_valid, result.head_task,
                     result.running_count);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_empty_queue();
    test_ordering();
    test_full_queue();
    test_random_mix();
    start <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
